// ===== src/fir21_pkg.sv =====
package fir21_pkg;

    localparam int TAPS           = 21;
    localparam int HIST_DEPTH     = TAPS - 1;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int ACC_BITS       = 32;
    localparam int OUT_BITS       = 17;
    localparam int ADDR_BITS      = 5;
    localparam int TAP_BITS       = 5;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic signed [OUT_BITS-1:0]    t_out;
    typedef logic [ADDR_BITS-1:0]          t_addr;
    typedef logic [TAP_BITS-1:0]           t_tap;

    localparam t_tap  TAP_LAST   = t_tap'(TAPS - 1);
    localparam t_tap  TAP_CENTER = t_tap'((TAPS - 1) / 2);
    localparam t_addr ADDR_LAST  = t_addr'(HIST_DEPTH - 1);
    localparam t_acc  ROUND_HALF = t_acc'(1) <<< (COEF_FRAC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // mac unit control from the sequencer
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    // result load request to the output stage
    typedef struct packed {
        logic load;
        logic full;
    } t_res_ctl;

    // q1.15 coefficients, symmetric around the center tap
    function automatic t_coef coef_of(input t_tap tap);
        t_tap k;
        t_coef c;
        k = (tap >= TAP_CENTER) ? t_tap'(tap - TAP_CENTER) : t_tap'(TAP_CENTER - tap);
        case (k)
            5'd0:    c = 16'sd6486;
            5'd1:    c = 16'sd5626;
            5'd2:    c = 16'sd3421;
            5'd3:    c = 16'sd792;
            5'd4:    c = -16'sd1279;
            5'd5:    c = -16'sd2230;
            5'd6:    c = -16'sd2107;
            5'd7:    c = -16'sd1400;
            5'd8:    c = -16'sd667;
            5'd9:    c = -16'sd211;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/fir21_hist_ram.sv =====
module fir21_hist_ram (
    input  logic             i_clk,
    input  logic             i_we,
    input  fir21_pkg::t_addr i_waddr,
    input  fir21_pkg::t_sample i_wdata,
    input  fir21_pkg::t_addr i_raddr,
    output fir21_pkg::t_sample o_rdata
);
    import fir21_pkg::*;

    t_sample r_mem [HIST_DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fir21_mac.sv =====
module fir21_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fir21_pkg::t_mac_ctl i_ctl,
    input  fir21_pkg::t_sample  i_operand,
    input  fir21_pkg::t_coef    i_coef,
    output fir21_pkg::t_acc     o_acc,
    output logic                o_busy
);
    import fir21_pkg::*;

    t_acc r_prod;
    logic r_pv;
    t_acc r_acc;

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
        r_prod <= t_acc'(i_operand * i_coef);
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pv;

    a_no_clear_mid_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |-> !r_pv && !i_ctl.valid)
        else $error("accumulator cleared while products in flight");

    a_pv_follows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctl.valid) |-> r_pv)
        else $error("product stage lost a tap");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_acc == '0)
        else $error("accumulator not cleared");

endmodule

// ===== src/fir21_seq.sv =====
module fir21_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fir21_pkg::t_sample  i_sample,
    output logic                o_stall,
    output fir21_pkg::t_addr    o_raddr,
    input  fir21_pkg::t_sample  i_rdata,
    output logic                o_we,
    output fir21_pkg::t_addr    o_waddr,
    output fir21_pkg::t_sample  o_wdata,
    output fir21_pkg::t_mac_ctl o_mac,
    output fir21_pkg::t_sample  o_operand,
    output fir21_pkg::t_coef    o_coef,
    input  logic                i_mac_busy,
    input  logic                i_out_free,
    output fir21_pkg::t_res_ctl o_res
);
    import fir21_pkg::*;

    t_state  r_state, n_state;
    t_tap    r_tap,   n_tap;
    t_tap    r_tap1;
    logic    r_v1;
    t_addr   r_head,  n_head;
    t_tap    r_count, n_count;
    t_sample r_x,     n_x;
    logic    r_full,  n_full;

    logic [ADDR_BITS:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_v1    <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_v1    <= (r_state == ST_RUN);
            r_full  <= n_full;
        end
        r_tap  <= n_tap;
        r_tap1 <= r_tap;
        r_x    <= n_x;
    end

    // history[j] sits at head-1-j, so tap t reads head-t
    always_comb begin
        diff = {1'b0, r_head} + (ADDR_BITS+1)'(HIST_DEPTH) - {1'b0, r_tap};
        if (diff >= (ADDR_BITS+1)'(HIST_DEPTH)) begin
            o_raddr = t_addr'(diff - (ADDR_BITS+1)'(HIST_DEPTH));
        end else begin
            o_raddr = diff[ADDR_BITS-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        n_head    = r_head;
        n_count   = r_count;
        n_x       = r_x;
        n_full    = r_full;
        o_stall   = 1'b1;
        o_we      = 1'b0;
        o_mac     = '0;
        o_res     = '0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_x         = i_sample;
                    n_full      = (r_count == t_tap'(HIST_DEPTH));
                    n_tap       = '0;
                    o_mac.clear = 1'b1;
                    n_state     = n_full ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN: begin
                if (r_tap == TAP_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !i_mac_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    o_res.full = r_full;
                    o_we       = 1'b1;
                    n_head     = (r_head == ADDR_LAST) ? '0 : r_head + 1'b1;
                    if (r_count != t_tap'(HIST_DEPTH)) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_mac.valid = r_v1;
    end

    assign o_operand = (r_tap1 == '0) ? r_x : i_rdata;
    assign o_coef    = coef_of(r_tap1);
    assign o_waddr   = r_head;
    assign o_wdata   = r_x;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_tap'(HIST_DEPTH) && r_head <= ADDR_LAST)
        else $error("warm-up count or write pointer out of range");

    a_full_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && i_valid && (r_count == t_tap'(HIST_DEPTH))
        |=> r_state == ST_RUN)
        else $error("full window did not start the tap sweep");

    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || i_mac_busy) |-> !o_we)
        else $error("history written while taps still being read");

endmodule

// ===== src/fir_filter_21_tap_top.sv =====
// 21-tap symmetric fir filter on signed 16-bit samples with q1.15 coefficients.
// the last 20 samples live in a single-port-read history ram used as a ring
// buffer; one multiply-accumulate unit walks the 21 taps one per cycle. a
// sample with a full window passes the 21 tap reads, a ram/multiplier drain,
// posting the result and writing the sample back once the output slot is
// free, and an idle state that accepts the next transfer. during warm-up (the
// first 20 samples) a sample skips the tap reads and drain, filtered reads 0
// and window_full is low. the sum is rounded by adding 2^14 and an arithmetic
// shift right by 15 and always fits 17 signed bits. a finished result waits
// in the output register while the next sample is accepted.
module fir_filter_21_tap_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fir21_pkg::t_sample i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output fir21_pkg::t_out    o_filtered,
    output logic               o_window_full
);
    import fir21_pkg::*;

    // ring buffer port wires
    t_addr    raddr;
    t_sample  rdata;
    logic     we;
    t_addr    waddr;
    t_sample  wdata;

    // mac datapath wires
    t_mac_ctl mac_ctl;
    t_sample  operand;
    t_coef    coef;
    t_acc     acc;
    logic     mac_busy;

    // output stage
    t_res_ctl res;
    logic     out_free;
    logic     r_out_valid;
    t_out     r_filtered;
    logic     r_full;
    t_acc     rounded;

    fir21_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .o_stall    (o_stall),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_mac      (mac_ctl),
        .o_operand  (operand),
        .o_coef     (coef),
        .i_mac_busy (mac_busy),
        .i_out_free (out_free),
        .o_res      (res)
    );

    fir21_hist_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fir21_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_operand (operand),
        .i_coef    (coef),
        .o_acc     (acc),
        .o_busy    (mac_busy)
    );

    // round half up then drop the fraction bits
    assign rounded = acc + ROUND_HALF;

    // output slot can take a result if empty or being drained this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res.load) begin
            r_filtered <= res.full ? rounded[COEF_FRAC_BITS +: OUT_BITS] : '0;
            r_full     <= res.full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_filtered    = r_filtered;
    assign o_window_full = r_full;

    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_window_full |-> o_filtered == '0)
        else $error("nonzero output during warm-up");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |-> !(r_out_valid && i_stall))
        else $error("result overwrote a pending transfer");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |=> o_valid)
        else $error("loaded result not presented");

endmodule

// ===== tb/fir_filter_21_tap_top_tb.sv =====
`timescale 1ns / 1ps

module fir_filter_21_tap_top_tb;

    import fir21_pkg::*;

    // cycles with no transfer on either side before the run is declared hung;
    // it covers a full-window sample plus the longest gap and stall below
    localparam int HANG_LIMIT = 3000;
    // long enough to cover one more full-window result
    localparam int SETTLE_CYCLES = 40;
    localparam int CENTER = (TAPS - 1) / 2;

    // one result as the filter should post it
    typedef struct packed {
        t_out filtered;
        logic window_full;
    } t_fir_result;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_sample  i_sample;
    logic     o_valid;
    logic     i_stall;
    t_out     o_filtered;
    logic     o_window_full;

    // predictor state: past samples, newest first, and the warm-up count
    longint      past_samples [HIST_DEPTH];
    int          samples_seen;
    t_fir_result pending_outputs [$];
    t_fir_result head;

    int unsigned n_errors;
    int unsigned idle_cycles;
    int unsigned stall_left;
    // while set, neither side inserts gaps or stalls
    bit          calm;

    fir_filter_21_tap_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_filtered    (o_filtered),
        .o_window_full (o_window_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // coefficient in millionths by distance from the center tap
    function automatic longint coef_micro(input int span);
        case (span)
            0:       return 197950;
            1:       return 171696;
            2:       return 104393;
            3:       return 24176;
            4:       return -39035;
            5:       return -68050;
            6:       return -64294;
            7:       return -42716;
            8:       return -20344;
            9:       return -6436;
            default: return 0;
        endcase
    endfunction

    // q1.15 weight for a given delay, rounded to nearest, ties away from zero
    function automatic longint tap_weight(input int delay);
        int     span;
        longint micro;
        longint mag;
        longint q;
        span  = (delay >= CENTER) ? delay - CENTER : CENTER - delay;
        micro = coef_micro(span);
        mag   = (micro < 0) ? -micro : micro;
        q     = (mag * (longint'(1) <<< COEF_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
        return (micro < 0) ? -q : q;
    endfunction

    // advance the predicted filter by one sample and queue the result it owes
    task automatic predict_output(input t_sample s);
        longint      acc;
        t_fir_result r;
        r = '0;
        if (samples_seen >= HIST_DEPTH) begin
            acc = tap_weight(0) * longint'(s);
            for (int i = 1; i < TAPS; i++) begin
                acc += tap_weight(i) * past_samples[i-1];
            end
            // round half up, then arithmetic shift back to sample units
            acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
            r.filtered    = t_out'(acc >>> COEF_FRAC_BITS);
            r.window_full = 1'b1;
        end else begin
            samples_seen++;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            past_samples[i] = past_samples[i-1];
        end
        past_samples[0] = longint'(s);
        pending_outputs.push_back(r);
    endtask

    // every input transfer feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_output(i_sample);
        end
    end

    // every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %0d/%0b",
                         $time, o_filtered, o_window_full);
                n_errors++;
            end else begin
                head = pending_outputs.pop_front();
                if (o_filtered !== head.filtered) begin
                    $display("%0t: filtered mismatch, expected %0d, actual %0d",
                             $time, $signed(head.filtered), o_filtered);
                    n_errors++;
                end
                if (o_window_full !== head.window_full) begin
                    $display("%0t: window_full mismatch, expected %0b, actual %0b",
                             $time, head.window_full, o_window_full);
                    n_errors++;
                end
            end
        end
    end

    // receiver back-pressure: rare random-length bursts, so a stall can
    // span the point where the next result is ready behind the held one
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(999) < 4) begin
            stall_left <= $urandom_range(39);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // hang detection: any transfer restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transfer; valid stays high afterwards so back-to-back items
    // do not lower and raise it in the same step
    task automatic send_sample(input t_sample s);
        int gap;
        if (!calm && $urandom_range(99) < 15) begin
            // gap of random length so it lands on any phase of the mac walk
            gap = $urandom_range(30, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold the sender off until every queued result has been taken
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    // first 20 samples: results read 0 with window_full low, extremes shifted in
    task automatic test_warmup_window();
        t_sample warm [20];
        warm = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                 16'sh5555, -16'sh5556, 16'sh0100, -16'sh0100, 16'sh7fff,
                 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh3039, -16'sh3039,
                 16'sh03e8, -16'sh03e8, 16'sh4000, -16'sh4000, 16'sh0007};
        foreach (warm[i]) send_sample(warm[i]);
    endtask

    // first full-window results, on the sample extremes and around zero
    task automatic test_sample_extremes();
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sh0001);
        send_sample(16'sh0001);
    endtask

    // windows matched to the coefficient signs drive the output to its
    // largest magnitude, both polarities; outer taps are zero, so random there
    task automatic test_peak_response();
        longint w;
        bit     flip;
        for (int rep = 0; rep < 4; rep++) begin
            flip = rep[0];
            for (int d = TAPS - 1; d >= 0; d--) begin
                w = tap_weight(d);
                if (w == 0) begin
                    send_sample(t_sample'($urandom));
                end else if ((w > 0) ^ flip) begin
                    send_sample(16'sh7fff);
                end else begin
                    send_sample(-16'sh8000);
                end
            end
        end
    endtask

    // mostly full-range samples, with extremes and tiny values mixed in
    task automatic test_random_stream(input int count);
        t_sample s;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0:       s = 16'sh7fff;
                1:       s = -16'sh8000;
                2:       s = t_sample'(int'($urandom_range(15)) - 8);
                default: s = t_sample'($urandom);
            endcase
            send_sample(s);
        end
    endtask

    // twice, the sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        for (int rep = 0; rep < 2; rep++) begin
            test_random_stream(80);
            wait_for_drain();
        end
    endtask

    // long stretch with no gaps and no back-pressure
    task automatic test_unbroken_stream();
        calm = 1'b1;
        test_random_stream(300);
        calm = 1'b0;
    endtask

    // small samples keep the sum near the rounding boundary on both signs
    task automatic test_small_amplitude();
        for (int n = 0; n < 300; n++) begin
            send_sample(t_sample'(int'($urandom_range(127)) - 64));
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_sample <= '0;
        i_stall  <= 1'b0;
        n_errors     = 0;
        samples_seen = 0;
        calm         = 1'b0;
        foreach (past_samples[i]) past_samples[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_warmup_window();
        test_sample_extremes();
        test_peak_response();
        test_random_stream(1080);
        test_drain_pause();
        test_unbroken_stream();
        test_small_amplitude();

        // all stimulus sent; collect the tail and let the block settle
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fir21_pkg.sv
src/fir21_hist_ram.sv
src/fir21_mac.sv
src/fir21_seq.sv
src/fir_filter_21_tap_top.sv
tb/fir_filter_21_tap_top_tb.sv
